FILE: hw/rtl/lla_pkg.sv
// Shared types, constants and register codes of the life-like automaton core.
package lla_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int SIZE_W    = 7;
    localparam int MASK_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int COUNT_W   = 4;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BORN_MASK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MASK = 2'd3;

    localparam logic [SIZE_W-1:0] GRID_WIDTH_RST   = 7'd64;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST  = 7'd64;
    localparam logic [MASK_W-1:0] BORN_MASK_RST    = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = 9'd12;

    localparam logic [SIZE_W-1:0] MIN_SIZE = 7'd3;

    typedef struct packed {
        logic [MASK_W-1:0] born;
        logic [MASK_W-1:0] survive;
    } rule_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_GEN_PREV,
        ST_GEN_CUR,
        ST_GEN_ROW,
        ST_RESP
    } state_t;

endpackage

FILE: hw/rtl/lla_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface lla_req_if;
    logic                           valid;
    logic                           ready;
    logic [lla_pkg::OP_W-1:0]       opcode;
    logic [lla_pkg::COORD_W-1:0]    col_index;
    logic [lla_pkg::COORD_W-1:0]    row_index;
    logic                           write_value;

    modport source (output valid, output opcode, output col_index, output row_index,
                    output write_value, input ready);
    modport sink (input valid, input opcode, input col_index, input row_index,
                  input write_value, output ready);
endinterface

interface lla_rsp_if;
    logic valid;
    logic ready;
    logic read_value;
    logic coord_error;

    modport source (output valid, output read_value, output coord_error, input ready);
    modport sink (input valid, input read_value, input coord_error, output ready);
endinterface

FILE: hw/rtl/lla_grid_mem.sv
// Row-wide grid memory: one write port, one read port, registered read data.
module lla_grid_mem #(
    parameter int DEPTH = lla_pkg::MAX_HEIGHT_DEF,
    parameter int WIDTH = lla_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/lla_row_unit.sv
// One lane per column: neighbor count and birth/survival rule for a whole row.
module lla_row_unit #(
    parameter int WIDTH = lla_pkg::MAX_WIDTH_DEF
) (
    input  logic [WIDTH-1:0]                 prev_row,
    input  logic [WIDTH-1:0]                 cur_row,
    input  logic [WIDTH-1:0]                 next_row,
    input  logic [$clog2(WIDTH+1)-1:0]       width_use,
    input  lla_pkg::rule_t                   rule,
    output logic [WIDTH-1:0]                 new_row
);

    localparam int COL_W = $clog2(WIDTH);

    logic [COL_W-1:0] last_col;

    assign last_col = COL_W'(width_use - 1'b1);

    for (genvar c = 0; c < WIDTH; c++)
    begin : g_lane
        logic                          lp, lc, ln, rp, rc, rn;
        logic [lla_pkg::COUNT_W-1:0]   count;

        // The left neighbor of column zero wraps to the last column in use.
        if (c == 0)
        begin : g_left_wrap
            assign lp = prev_row[last_col];
            assign lc = cur_row[last_col];
            assign ln = next_row[last_col];
        end
        else
        begin : g_left
            assign lp = prev_row[c-1];
            assign lc = cur_row[c-1];
            assign ln = next_row[c-1];
        end

        // A lane in use at the top column is necessarily the last one in use.
        if (c == WIDTH - 1)
        begin : g_right_wrap
            assign rp = prev_row[0];
            assign rc = cur_row[0];
            assign rn = next_row[0];
        end
        else
        begin : g_right
            assign rp = (COL_W'(c) == last_col) ? prev_row[0] : prev_row[c+1];
            assign rc = (COL_W'(c) == last_col) ? cur_row[0]  : cur_row[c+1];
            assign rn = (COL_W'(c) == last_col) ? next_row[0] : next_row[c+1];
        end

        assign count = lla_pkg::COUNT_W'(lp) + lla_pkg::COUNT_W'(prev_row[c])
                     + lla_pkg::COUNT_W'(rp) + lla_pkg::COUNT_W'(lc)
                     + lla_pkg::COUNT_W'(rc) + lla_pkg::COUNT_W'(ln)
                     + lla_pkg::COUNT_W'(next_row[c]) + lla_pkg::COUNT_W'(rn);

        always_comb
        begin
            if (($clog2(WIDTH+1))'(c) < width_use)
            begin
                new_row[c] = cur_row[c] ? rule.survive[count] : rule.born[count];
            end
            else
            begin
                new_row[c] = cur_row[c];
            end
        end
    end

endmodule

FILE: hw/rtl/life_like_automaton_torus_core.sv
// Life-like cellular automaton on a wrapped grid: sequencer, config and result stage.
//
// Requests arrive on req (opcode, col_index, row_index, write_value) and each one
// produces exactly one transfer on rsp (read_value, coord_error). Configuration
// registers are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. The grid
// lives in a memory of MAX_HEIGHT rows, each MAX_WIDTH cells wide. A cell read or
// write takes a row read and, for a write, a row write back, passing through the cell
// state and the result state; the next request waits for the idle state.
// An advance sweeps the rows in use one per cycle through a sliding three-row
// window, with a lane per column doing the neighbor count, and passes through the
// result state. Out-of-range coordinates and the unused opcode go straight to the
// result state. One request is in work at a time; req.ready is high only while
// waiting. After reset the block clears all MAX_HEIGHT rows one per cycle and takes
// no request meanwhile. The response sits in an output register, so a new request is
// taken while the previous response still waits; if the receiver stalls, the next
// response holds in the sequencer until the register frees up.
module life_like_automaton_torus_core #(
    parameter int MAX_WIDTH  = lla_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lla_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lla_req_if.sink                           req,
    lla_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [lla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lla_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WU_W  = $clog2(MAX_WIDTH + 1);
    localparam int HU_W  = $clog2(MAX_HEIGHT + 1);

    lla_pkg::state_t state_reg, state_next;

    logic [lla_pkg::SIZE_W-1:0]  grid_width_reg;
    logic [lla_pkg::SIZE_W-1:0]  grid_height_reg;
    logic [lla_pkg::MASK_W-1:0]  born_mask_reg;
    logic [lla_pkg::MASK_W-1:0]  survive_mask_reg;

    logic [ROW_W-1:0]            row_cnt_reg;
    logic [lla_pkg::OP_W-1:0]    op_reg;
    logic [COL_W-1:0]            col_reg;
    logic [ROW_W-1:0]            row_reg;
    logic                        val_reg;
    logic [MAX_WIDTH-1:0]        prev_reg, cur_reg, first_reg;
    logic                        res_rv_reg, res_err_reg;
    logic                        out_valid_reg, out_rv_reg, out_err_reg;

    logic [WU_W-1:0]             width_use;
    logic [HU_W-1:0]             height_use;
    logic [ROW_W-1:0]            last_row;
    logic                        in_range;
    logic                        is_cell_op;
    logic                        accept;
    logic                        out_load;

    logic                        mem_we, mem_re;
    logic [ROW_W-1:0]            mem_waddr, mem_raddr;
    logic [MAX_WIDTH-1:0]        mem_wdata, mem_rdata;
    logic [MAX_WIDTH-1:0]        cell_row;
    logic [MAX_WIDTH-1:0]        next_row;
    logic [MAX_WIDTH-1:0]        new_row;
    lla_pkg::rule_t              rule;

    // Sizes in use are the size registers saturated to 3..MAX.
    always_comb
    begin
        priority if (grid_width_reg < lla_pkg::MIN_SIZE)
        begin
            width_use = WU_W'(lla_pkg::MIN_SIZE);
        end
        else if (int'(grid_width_reg) > MAX_WIDTH)
        begin
            width_use = WU_W'(MAX_WIDTH);
        end
        else
        begin
            width_use = WU_W'(grid_width_reg);
        end

        priority if (grid_height_reg < lla_pkg::MIN_SIZE)
        begin
            height_use = HU_W'(lla_pkg::MIN_SIZE);
        end
        else if (int'(grid_height_reg) > MAX_HEIGHT)
        begin
            height_use = HU_W'(MAX_HEIGHT);
        end
        else
        begin
            height_use = HU_W'(grid_height_reg);
        end
    end

    assign last_row   = ROW_W'(height_use - 1'b1);
    assign in_range   = (req.col_index < width_use) && (req.row_index < height_use);
    assign is_cell_op = (req.opcode == lla_pkg::OP_WRITE) || (req.opcode == lla_pkg::OP_READ);
    assign accept     = req.valid && req.ready;

    assign rule.born    = born_mask_reg;
    assign rule.survive = survive_mask_reg;

    // The row after the last one in use wraps to the saved copy of old row zero.
    assign next_row = (row_cnt_reg == last_row) ? first_reg : mem_rdata;

    always_comb
    begin
        cell_row          = mem_rdata;
        cell_row[col_reg] = val_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = row_cnt_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            lla_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (row_cnt_reg == ROW_W'(MAX_HEIGHT - 1))
                begin
                    state_next = lla_pkg::ST_IDLE;
                end
            end
            lla_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    priority if (is_cell_op && in_range)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ROW_W'(req.row_index);
                        state_next = lla_pkg::ST_CELL;
                    end
                    else if (req.opcode == lla_pkg::OP_ADVANCE)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = last_row;
                        state_next = lla_pkg::ST_GEN_PREV;
                    end
                    else
                    begin
                        state_next = lla_pkg::ST_RESP;
                    end
                end
            end
            lla_pkg::ST_CELL:
            begin
                if (op_reg == lla_pkg::OP_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = row_reg;
                    mem_wdata = cell_row;
                end
                state_next = lla_pkg::ST_RESP;
            end
            lla_pkg::ST_GEN_PREV:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = lla_pkg::ST_GEN_CUR;
            end
            lla_pkg::ST_GEN_CUR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ROW_W'(1);
                state_next = lla_pkg::ST_GEN_ROW;
            end
            lla_pkg::ST_GEN_ROW:
            begin
                // Row r is written while row r + 2 is fetched; neither overlaps.
                mem_we     = 1'b1;
                mem_waddr  = row_cnt_reg;
                mem_wdata  = new_row;
                mem_re     = 1'b1;
                mem_raddr  = row_cnt_reg + ROW_W'(2);
                if (row_cnt_reg == last_row)
                begin
                    state_next = lla_pkg::ST_RESP;
                end
            end
            lla_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = lla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lla_pkg::ST_CLEAR;
            row_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            grid_width_reg   <= lla_pkg::GRID_WIDTH_RST;
            grid_height_reg  <= lla_pkg::GRID_HEIGHT_RST;
            born_mask_reg    <= lla_pkg::BORN_MASK_RST;
            survive_mask_reg <= lla_pkg::SURVIVE_MASK_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    lla_pkg::REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[lla_pkg::SIZE_W-1:0];
                    lla_pkg::REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[lla_pkg::SIZE_W-1:0];
                    lla_pkg::REG_BORN_MASK:    born_mask_reg    <= cfg_data[lla_pkg::MASK_W-1:0];
                    lla_pkg::REG_SURVIVE_MASK: survive_mask_reg <= cfg_data[lla_pkg::MASK_W-1:0];
                endcase
            end

            if (state_reg == lla_pkg::ST_CLEAR || state_reg == lla_pkg::ST_GEN_ROW)
            begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            else if (state_reg == lla_pkg::ST_GEN_CUR)
            begin
                row_cnt_reg <= '0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.opcode;
            col_reg     <= COL_W'(req.col_index);
            row_reg     <= ROW_W'(req.row_index);
            val_reg     <= req.write_value;
            res_rv_reg  <= 1'b0;
            res_err_reg <= is_cell_op && !in_range;
        end

        if (state_reg == lla_pkg::ST_CELL)
        begin
            res_rv_reg <= (op_reg == lla_pkg::OP_WRITE) ? val_reg : mem_rdata[col_reg];
        end

        if (state_reg == lla_pkg::ST_GEN_PREV)
        begin
            prev_reg <= mem_rdata;
        end
        else if (state_reg == lla_pkg::ST_GEN_CUR)
        begin
            cur_reg   <= mem_rdata;
            first_reg <= mem_rdata;
        end
        else if (state_reg == lla_pkg::ST_GEN_ROW)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= next_row;
        end

        if (out_load)
        begin
            out_rv_reg  <= res_rv_reg;
            out_err_reg <= res_err_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_rv_reg;
    assign rsp.coord_error = out_err_reg;

    lla_grid_mem #(
        .DEPTH (MAX_HEIGHT),
        .WIDTH (MAX_WIDTH)
    ) u_grid_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lla_row_unit #(
        .WIDTH (MAX_WIDTH)
    ) u_row_unit (
        .prev_row  (prev_reg),
        .cur_row   (cur_reg),
        .next_row  (next_row),
        .width_use (width_use),
        .rule      (rule),
        .new_row   (new_row)
    );

endmodule

FILE: hw/rtl/lla_checker.sv
// Port-level checks of the automaton core and their attachment to it.
module lla_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic read_value,
    input logic coord_error
);

    // A response waiting for the receiver must stay offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(read_value) && $stable(coord_error))
        else $error("response payload changed while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // A rejected coordinate never reports a cell value.
    a_err_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(read_value && coord_error))
        else $error("coordinate error with a cell value");

endmodule

bind life_like_automaton_torus_core lla_checker u_lla_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_value  (rsp.read_value),
    .coord_error (rsp.coord_error)
);

FILE: dv/life_like_automaton_torus_core_test.sv
// Self-checking testbench for the life-like automaton core on a wrapped grid.
module life_like_automaton_torus_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 12;
    localparam int BURST_PHASE     = 4;
    localparam int LONG_HOLD       = 150;
    localparam int TAIL_CYCLES     = lla_pkg::MAX_HEIGHT_DEF + 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int COORD_MAX       = (1 << lla_pkg::COORD_W) - 1;
    localparam int MASK_MAX        = (1 << lla_pkg::MASK_W) - 1;

    localparam logic [lla_pkg::CFG_DATA_W-1:0] CFG_SIZE_MIN =
        lla_pkg::CFG_DATA_W'(lla_pkg::MIN_SIZE);
    localparam logic [lla_pkg::CFG_DATA_W-1:0] CFG_ALL_ONES = '1;
    localparam logic [lla_pkg::CFG_DATA_W-1:0] CFG_ZERO     = '0;

    typedef struct {
        logic [lla_pkg::OP_W-1:0]    op;
        logic [lla_pkg::COORD_W-1:0] col;
        logic [lla_pkg::COORD_W-1:0] row;
        logic                        wval;
    } cell_req_t;

    typedef struct {
        logic value;
        logic coord_error;
    } cell_answer_t;

    // Tracks the grid and rule registers and queues the answer each request should get.
    class automaton_tracker;
        bit                         grid [lla_pkg::MAX_HEIGHT_DEF][lla_pkg::MAX_WIDTH_DEF];
        logic [lla_pkg::SIZE_W-1:0] width_reg;
        logic [lla_pkg::SIZE_W-1:0] height_reg;
        logic [lla_pkg::MASK_W-1:0] born;
        logic [lla_pkg::MASK_W-1:0] survive;
        cell_answer_t               answers [$];
        int mismatches;
        int n_write;
        int n_read;
        int n_advance;
        int n_nop;
        int n_flagged;
        int n_checked;
        int n_rules;

        function new();
            width_reg  = lla_pkg::GRID_WIDTH_RST;
            height_reg = lla_pkg::GRID_HEIGHT_RST;
            born       = lla_pkg::BORN_MASK_RST;
            survive    = lla_pkg::SURVIVE_MASK_RST;
        endfunction

        function int span(logic [lla_pkg::SIZE_W-1:0] v, int limit);
            if (v < lla_pkg::MIN_SIZE)
                return int'(lla_pkg::MIN_SIZE);
            if (int'(v) > limit)
                return limit;
            return int'(v);
        endfunction

        function int area_cols();
            return span(width_reg, lla_pkg::MAX_WIDTH_DEF);
        endfunction

        function int area_rows();
            return span(height_reg, lla_pkg::MAX_HEIGHT_DEF);
        endfunction

        function void set_register(logic [lla_pkg::CFG_IDX_W-1:0] idx,
                                   logic [lla_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lla_pkg::REG_GRID_WIDTH:   width_reg  = data[lla_pkg::SIZE_W-1:0];
                lla_pkg::REG_GRID_HEIGHT:  height_reg = data[lla_pkg::SIZE_W-1:0];
                lla_pkg::REG_BORN_MASK:    born       = data[lla_pkg::MASK_W-1:0];
                lla_pkg::REG_SURVIVE_MASK: survive    = data[lla_pkg::MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Every cell in the area counts its wrapped neighbors in the old grid;
        // cells beyond the area are left alone.
        function void evolve(int w, int h);
            bit prev [lla_pkg::MAX_HEIGHT_DEF][lla_pkg::MAX_WIDTH_DEF];
            int n;
            int rp;
            int rn;
            int cp;
            int cn;
            prev = grid;
            for (int r = 0; r < h; r++)
            begin
                rp = (r + h - 1) % h;
                rn = (r + 1) % h;
                for (int c = 0; c < w; c++)
                begin
                    cp = (c + w - 1) % w;
                    cn = (c + 1) % w;
                    n = int'(prev[rp][cp]) + int'(prev[rp][c]) + int'(prev[rp][cn])
                      + int'(prev[r][cp]) + int'(prev[r][cn])
                      + int'(prev[rn][cp]) + int'(prev[rn][c]) + int'(prev[rn][cn]);
                    grid[r][c] = prev[r][c] ? survive[n] : born[n];
                end
            end
        endfunction

        function void take_request(cell_req_t r);
            cell_answer_t a;
            int w;
            int h;
            w = area_cols();
            h = area_rows();
            a.value = 1'b0;
            a.coord_error = 1'b0;
            case (r.op)
                lla_pkg::OP_WRITE, lla_pkg::OP_READ:
                begin
                    if (r.op == lla_pkg::OP_WRITE)
                        n_write++;
                    else
                        n_read++;
                    if (int'(r.col) >= w || int'(r.row) >= h)
                    begin
                        a.coord_error = 1'b1;
                        n_flagged++;
                    end
                    else if (r.op == lla_pkg::OP_WRITE)
                    begin
                        grid[r.row][r.col] = r.wval;
                        a.value = r.wval;
                    end
                    else
                        a.value = grid[r.row][r.col];
                end
                lla_pkg::OP_ADVANCE:
                begin
                    n_advance++;
                    evolve(w, h);
                end
                default: n_nop++;
            endcase
            answers.push_back(a);
        endfunction

        function void check_response(logic rv, logic ce);
            cell_answer_t a;
            if (answers.size() == 0)
            begin
                $error("unexpected response transfer: read_value=%0d coord_error=%0d",
                       rv, ce);
                mismatches++;
                return;
            end
            a = answers.pop_front();
            n_checked++;
            if (rv !== a.value)
            begin
                $error("read_value: expected %0d, actual %0d", a.value, rv);
                mismatches++;
            end
            if (ce !== a.coord_error)
            begin
                $error("coord_error: expected %0d, actual %0d", a.coord_error, ce);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                           cfg_we;
    logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lla_pkg::CFG_DATA_W-1:0] cfg_data;

    lla_req_if req_ch ();
    lla_rsp_if rsp_ch ();

    automaton_tracker tracker;
    bit hold_off_armed;
    int long_holds;
    int stall_cycles;

    life_like_automaton_torus_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic cell_req_t make_req(logic [lla_pkg::OP_W-1:0] op, int col, int row,
                                           bit wv);
        cell_req_t r;
        r.op   = op;
        r.col  = lla_pkg::COORD_W'(col);
        r.row  = lla_pkg::COORD_W'(row);
        r.wval = wv;
        return r;
    endfunction

    // Mostly well-formed traffic inside the area, with some raw noise over the full field ranges.
    function automatic cell_req_t random_req(int w, int h);
        cell_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.wval = 1'($urandom_range(0, 1));
        if (pick < 15)
        begin
            r.op  = lla_pkg::OP_W'($urandom_range(0, (1 << lla_pkg::OP_W) - 1));
            r.col = lla_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            r.row = lla_pkg::COORD_W'($urandom_range(0, COORD_MAX));
        end
        else
        begin
            r.col = lla_pkg::COORD_W'($urandom_range(0, w - 1));
            r.row = lla_pkg::COORD_W'($urandom_range(0, h - 1));
            if (pick < 50)
                r.op = lla_pkg::OP_WRITE;
            else if (pick < 80)
                r.op = lla_pkg::OP_READ;
            else
                r.op = lla_pkg::OP_ADVANCE;
        end
        return r;
    endfunction

    // Small sizes mostly; now and then any 7-bit value, which the block saturates.
    // The bits above the size field carry junk that must be ignored.
    function automatic logic [lla_pkg::CFG_DATA_W-1:0] random_size();
        logic [lla_pkg::CFG_DATA_W-1:0] v;
        v = lla_pkg::CFG_DATA_W'($urandom_range(0, (1 << lla_pkg::CFG_DATA_W) - 1));
        if ($urandom_range(0, 5) != 0)
            v[lla_pkg::SIZE_W-1:0] = lla_pkg::SIZE_W'($urandom_range(lla_pkg::MIN_SIZE, 8));
        return v;
    endfunction

    function automatic logic [lla_pkg::CFG_DATA_W-1:0] random_mask(
        logic [lla_pkg::MASK_W-1:0] classic);
        if ($urandom_range(0, 3) == 0)
            return lla_pkg::CFG_DATA_W'(classic);
        return lla_pkg::CFG_DATA_W'($urandom_range(0, MASK_MAX));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input cell_req_t it, input int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= it.op;
        req_ch.col_index   <= it.col;
        req_ch.row_index   <= it.row;
        req_ch.write_value <= it.wval;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.take_request(it);
        @(negedge clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (tracker.answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [lla_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lla_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        tracker.set_register(idx, data);
    endtask

    task automatic apply_rule(input logic [lla_pkg::CFG_DATA_W-1:0] w,
                              input logic [lla_pkg::CFG_DATA_W-1:0] h,
                              input logic [lla_pkg::CFG_DATA_W-1:0] b,
                              input logic [lla_pkg::CFG_DATA_W-1:0] s);
        write_register(lla_pkg::REG_GRID_WIDTH, w);
        write_register(lla_pkg::REG_GRID_HEIGHT, h);
        write_register(lla_pkg::REG_BORN_MASK, b);
        write_register(lla_pkg::REG_SURVIVE_MASK, s);
        tracker.n_rules++;
    endtask

    // Response side: random back-pressure, quiet stretches, and one long hold-off.
    initial
    begin
        int gap;
        int quiet_left;
        quiet_left = 0;
        rsp_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_armed)
            begin
                gap = LONG_HOLD;
                hold_off_armed = 1'b0;
                long_holds++;
            end
            else if (quiet_left > 0)
            begin
                gap = 0;
                quiet_left--;
            end
            else
            begin
                gap = $urandom_range(0, 9);
                if ($urandom_range(0, 15) == 0)
                    quiet_left = 20;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            tracker.check_response(rsp_ch.read_value, rsp_ch.coord_error);
            @(negedge clk);
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        bit quiet;
        tracker = new();
        hold_off_armed = 1'b0;
        long_holds = 0;
        stall_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = lla_pkg::OP_NOP;
        req_ch.col_index = '0;
        req_ch.row_index = '0;
        req_ch.write_value = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset rule on the full grid: a horizontal blinker that wraps across the last column.
        send_item(make_req(lla_pkg::OP_READ, 0, 0, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_READ, COORD_MAX, COORD_MAX, 1'b1), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_WRITE, COORD_MAX, 0, 1'b1), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_WRITE, 0, 0, 1'b1), 0);
        send_item(make_req(lla_pkg::OP_WRITE, 1, 0, 1'b1), 0);
        send_item(make_req(lla_pkg::OP_READ, COORD_MAX, 0, 1'b0), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_WRITE, 5, 5, 1'b1), 0);
        send_item(make_req(lla_pkg::OP_WRITE, 5, 5, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_NOP, COORD_MAX, COORD_MAX, 1'b1), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_ADVANCE, COORD_MAX, COORD_MAX, 1'b1), 0);
        send_item(make_req(lla_pkg::OP_READ, 0, COORD_MAX, 1'b0), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_READ, 0, 1, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_READ, COORD_MAX, 0, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_ADVANCE, 0, 0, 1'b0), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_READ, COORD_MAX, 0, 1'b0), 0);
        settle();

        // Smallest torus, every count born and nothing survives; coordinates just past the edge.
        apply_rule(CFG_SIZE_MIN, CFG_SIZE_MIN, CFG_ALL_ONES, CFG_ZERO);
        send_item(make_req(lla_pkg::OP_WRITE, 2, 2, 1'b1), 0);
        send_item(make_req(lla_pkg::OP_WRITE, 3, 0, 1'b1), 0);
        send_item(make_req(lla_pkg::OP_READ, 0, 3, 1'b0), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_READ, COORD_MAX, COORD_MAX, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_ADVANCE, 0, 0, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_READ, 0, 0, 1'b0), $urandom_range(0, 9));
        send_item(make_req(lla_pkg::OP_READ, 2, 2, 1'b0), 0);
        settle();

        // Sizes below and above range saturate; nothing is born and everything survives.
        apply_rule(CFG_ZERO, CFG_ALL_ONES, CFG_ZERO, CFG_ALL_ONES);
        send_item(make_req(lla_pkg::OP_ADVANCE, 0, 0, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_READ, 1, 40, 1'b0), 0);
        send_item(make_req(lla_pkg::OP_READ, 5, 5, 1'b0), 0);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_rule(random_size(), random_size(),
                       random_mask(lla_pkg::BORN_MASK_RST),
                       random_mask(lla_pkg::SURVIVE_MASK_RST));
            // In the burst phase the sender never idles while the receiver holds off,
            // so the block backs up and stops taking requests.
            if (p == BURST_PHASE)
                hold_off_armed = 1'b1;
            quiet = (p == BURST_PHASE) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(random_req(tracker.area_cols(), tracker.area_rows()),
                          quiet ? 0 : $urandom_range(0, 9));
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.answers.size() != 0)
        begin
            $error("%0d responses never arrived", tracker.answers.size());
            tracker.mismatches++;
        end

        $display("covered %0d writes, %0d reads, %0d advances, %0d no-ops, %0d off-grid",
                 tracker.n_write, tracker.n_read, tracker.n_advance, tracker.n_nop,
                 tracker.n_flagged);
        $display("%0d rule settings, %0d long hold-offs, %0d responses checked, %0d mismatches",
                 tracker.n_rules, long_holds, tracker.n_checked, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/lla_pkg.sv
hw/rtl/lla_if.sv
hw/rtl/lla_grid_mem.sv
hw/rtl/lla_row_unit.sv
hw/rtl/life_like_automaton_torus_core.sv
hw/rtl/lla_checker.sv
dv/life_like_automaton_torus_core_test.sv
